@@ rtl/core/u2c_pkg.sv @@
// Shared types, constants and helpers for the UTF-8 to code point decoder.
`default_nettype none
package u2c_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam int CP_W        = 21;
   localparam int MAX_RESULTS = 3;

   localparam logic [CP_W-1:0] CP_MIN_2 = 21'h000080;
   localparam logic [CP_W-1:0] CP_MIN_3 = 21'h000800;
   localparam logic [CP_W-1:0] CP_MIN_4 = 21'h010000;
   localparam logic [CP_W-1:0] CP_MAX   = 21'h10FFFF;
   localparam logic [CP_W-1:0] SURR_LO  = 21'h00D800;
   localparam logic [CP_W-1:0] SURR_HI  = 21'h00DFFF;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       end_of_text;
   } req_word_type;

   typedef struct packed {
      logic [CP_W-1:0] code_point;
      logic            last_in_run;
      logic            text_done;
   } rsp_word_type;

   typedef struct packed {
      logic [1:0]                        count;
      logic [MAX_RESULTS-1:0][CP_W-1:0]  code_points;
      logic                              end_of_text;
   } job_type;

   function automatic logic [2:0] seq_len(input logic [7:0] lead);
      logic [2:0] len;
      len = 3'd1;
      if (lead[7:5] == 3'b110) begin
         len = 3'd2;
      end else if (lead[7:4] == 4'b1110) begin
         len = 3'd3;
      end else if (lead[7:3] == 5'b11110) begin
         len = 3'd4;
      end
      return len;
   endfunction

   function automatic logic is_cont(input logic [7:0] b);
      return b[7:6] == 2'b10;
   endfunction

endpackage
`default_nettype wire

@@ rtl/core/utf8_to_codepoint_decoder_top.sv @@
// Top level of the UTF-8 to code point decoder.
// The decoder takes one text byte per cycle while req_full is low and delivers
// one code point word per cycle on the result side while rsp_pop is high. A byte
// that causes k results (k from 0 to 3) has them issued one after another by the
// result sequencer, so plain text sustains one byte per cycle, while held bytes
// that are replayed slow the result side; a job queue of QUEUE_DEPTH entries between
// the byte classifier and the result sequencer absorbs such bursts.
`default_nettype none
module utf8_to_codepoint_decoder_top #(
   parameter int QUEUE_DEPTH = u2c_pkg::QUEUE_DEPTH
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_push,
   output logic                       req_full,
   input  wire u2c_pkg::req_word_type req_word,
   output logic                       rsp_empty,
   input  wire logic                  rsp_pop,
   output u2c_pkg::rsp_word_type      rsp_word
);

   u2c_pkg::job_type enq_job;
   u2c_pkg::job_type head_job;
   logic             enq;
   logic             deq;
   logic             q_empty;
   logic             q_full;

   u2c_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_word   (req_word),
      .queue_full (q_full),
      .job_valid  (enq),
      .job        (enq_job)
   );

   u2c_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .enq      (enq),
      .enq_job  (enq_job),
      .deq      (deq),
      .head_job (head_job),
      .empty    (q_empty),
      .full     (q_full)
   );

   u2c_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_job   (head_job),
      .head_empty (q_empty),
      .deq        (deq),
      .rsp_pop    (rsp_pop),
      .rsp_empty  (rsp_empty),
      .rsp_word   (rsp_word)
   );

   assign req_full = q_full;

endmodule
`default_nettype wire

@@ rtl/core/u2c_front.sv @@
// Front end: accepts text bytes, tracks held sequences and builds result jobs.
`default_nettype none
module u2c_front (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_push,
   input  wire u2c_pkg::req_word_type req_word,
   input  wire logic                  queue_full,
   output logic                       job_valid,
   output u2c_pkg::job_type           job
);

   logic [7:0] held_lead_ff, held_lead_in;
   logic [1:0] held_count_ff, held_count_in;
   logic [7:0] cont_ff [2];
   logic       cont_wr;
   logic       accept;
   logic [7:0] b;
   logic       eot;
   logic [1:0] conts;
   logic [2:0] need;
   logic [2:0] have;
   logic       complete;
   logic       ok;
   logic [u2c_pkg::CP_W-1:0] cp2, cp3, cp4, cp_full;

   assign accept = req_push && !queue_full;
   assign b      = req_word.text_byte;
   assign eot    = req_word.end_of_text;
   assign conts  = (held_count_ff != 2'd0) ? held_count_ff - 2'd1 : 2'd0;
   assign need   = u2c_pkg::seq_len(held_lead_ff);
   assign have   = {1'b0, held_count_ff} + 3'd1;
   assign complete = have >= need;

   assign cp2 = {10'd0, held_lead_ff[4:0], b[5:0]};
   assign cp3 = {5'd0, held_lead_ff[3:0], cont_ff[0][5:0], b[5:0]};
   assign cp4 = {held_lead_ff[2:0], cont_ff[0][5:0], cont_ff[1][5:0], b[5:0]};

   always_comb begin
      cp_full = cp4;
      ok      = (cp4 >= u2c_pkg::CP_MIN_4) && (cp4 <= u2c_pkg::CP_MAX);
      case (need)
         3'd2: begin
            cp_full = cp2;
            ok      = cp2 >= u2c_pkg::CP_MIN_2;
         end
         3'd3: begin
            cp_full = cp3;
            ok      = (cp3 >= u2c_pkg::CP_MIN_3) &&
                      !((cp3 >= u2c_pkg::SURR_LO) && (cp3 <= u2c_pkg::SURR_HI));
         end
         default: begin
            cp_full = cp4;
            ok      = (cp4 >= u2c_pkg::CP_MIN_4) && (cp4 <= u2c_pkg::CP_MAX);
         end
      endcase
   end

   always_comb begin
      logic fresh;
      fresh            = 1'b1;
      cont_wr          = 1'b0;
      held_lead_in     = held_lead_ff;
      held_count_in    = held_count_ff;
      job.count        = 2'd0;
      job.end_of_text  = eot;
      job.code_points[0] = {13'd0, cont_ff[0]};
      job.code_points[1] = {13'd0, cont_ff[1]};
      job.code_points[2] = {13'd0, b};
      if (held_count_ff != 2'd0) begin
         if (u2c_pkg::is_cont(b)) begin
            fresh = 1'b0;
            if (complete && ok) begin
               job.count          = 2'd1;
               job.code_points[0] = cp_full;
               held_count_in      = 2'd0;
            end else if (complete || eot) begin
               job.count              = conts + 2'd1;
               job.code_points[conts] = {13'd0, b};
               held_count_in          = 2'd0;
            end else begin
               cont_wr       = 1'b1;
               held_count_in = held_count_ff + 2'd1;
            end
         end else begin
            job.count     = conts;
            held_count_in = 2'd0;
         end
      end
      if (fresh) begin
         if (u2c_pkg::seq_len(b) == 3'd1) begin
            job.code_points[job.count] = {13'd0, b};
            job.count                  = job.count + 2'd1;
         end else if (!eot) begin
            held_lead_in  = b;
            held_count_in = 2'd1;
         end
      end
      if (eot) begin
         held_count_in = 2'd0;
      end
   end

   assign job_valid = accept && (job.count != 2'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         held_count_ff <= 2'd0;
         held_lead_ff  <= 8'd0;
      end else if (accept) begin
         held_count_ff <= held_count_in;
         held_lead_ff  <= held_lead_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && cont_wr) begin
         cont_ff[conts[0]] <= b;
      end
   end

endmodule
`default_nettype wire

@@ rtl/core/u2c_queue.sv @@
// Short job queue between the front end and the result sequencer.
`default_nettype none
module u2c_queue #(
   parameter int DEPTH = u2c_pkg::QUEUE_DEPTH
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             enq,
   input  wire u2c_pkg::job_type enq_job,
   input  wire logic             deq,
   output u2c_pkg::job_type      head_job,
   output logic                  empty,
   output logic                  full
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

   u2c_pkg::job_type mem [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_enq;
   logic             do_deq;

   assign empty  = count_ff == '0;
   assign full   = count_ff == DEPTH_CNT;
   assign do_enq = enq && !full;
   assign do_deq = deq && !empty;
   assign head_job = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_enq) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_deq) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_enq && !do_deq) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_deq && !do_enq) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_enq) begin
         mem[wr_ptr_ff] <= enq_job;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_CNT)
      else $error("queue count above depth");

   a_deq_nonempty: assert property (@(posedge clock) disable iff (reset)
      deq |-> !empty)
      else $error("dequeue from empty queue");

   a_enq_grows: assert property (@(posedge clock) disable iff (reset)
      (enq && !full && !deq) |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("enqueue lost");

   a_deq_shrinks: assert property (@(posedge clock) disable iff (reset)
      (deq && !empty && !enq) |=> count_ff == $past(count_ff) - CNT_W'(1))
      else $error("dequeue lost");

endmodule
`default_nettype wire

@@ rtl/core/u2c_back.sv @@
// Back end: steps through each job's results into the output register.
`default_nettype none
module u2c_back (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire u2c_pkg::job_type      head_job,
   input  wire logic                  head_empty,
   output logic                       deq,
   input  wire logic                  rsp_pop,
   output logic                       rsp_empty,
   output u2c_pkg::rsp_word_type      rsp_word
);

   logic [1:0]            idx_ff, idx_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   u2c_pkg::rsp_word_type rsp_ff, rsp_in;
   logic                  load;
   logic                  last;

   assign load = !head_empty && (!rsp_valid_ff || rsp_pop);
   assign last = idx_ff == (head_job.count - 2'd1);
   assign deq  = load && last;

   always_comb begin
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_pop;
      rsp_in       = rsp_ff;
      if (load) begin
         rsp_valid_in       = 1'b1;
         rsp_in.code_point  = head_job.code_points[idx_ff];
         rsp_in.last_in_run = last;
         rsp_in.text_done   = head_job.end_of_text;
         idx_in             = last ? 2'd0 : idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_empty = !rsp_valid_ff;
   assign rsp_word  = rsp_ff;

endmodule
`default_nettype wire

@@ sim/utf8_to_codepoint_decoder_top_tb.sv @@
// Self-checking testbench for the UTF-8 to code point decoder: directed and random byte streams.
`timescale 1ns / 100ps
module utf8_to_codepoint_decoder_top_tb;

   localparam int RANDOM_ITEMS = 322;
   localparam int MAX_REPORTS  = 10;

   typedef struct packed {
      logic [7:0]  value;
      logic        eot;
      logic        typed;
      logic [20:0] cp;
   } byte_case_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_push = 1'b0;
   logic                  req_full;
   u2c_pkg::req_word_type req_word = '0;
   logic                  rsp_empty;
   logic                  rsp_pop = 1'b0;
   u2c_pkg::rsp_word_type rsp_word;

   int send_idle_pct = 0;
   int pop_stall_pct = 0;
   int fault_count = 0;
   int bytes_sent = 0;
   int texts_ended = 0;
   int words_checked = 0;

   logic [7:0]  held_lead = 8'h00;
   logic [7:0]  held_conts [0:1];
   logic [1:0]  held_count = 2'd0;
   logic [20:0] byte_results [$];
   u2c_pkg::rsp_word_type awaited_code_points [$];
   logic [7:0]  text_bytes [$];

   byte_case_type byte_cases [28] = '{
      '{8'h00, 1'b0, 1'b1, 21'h000000},
      '{8'h80, 1'b0, 1'b1, 21'h000080},
      '{8'hFF, 1'b0, 1'b1, 21'h0000FF},
      '{8'hC2, 1'b0, 1'b0, 21'h000000},
      '{8'h80, 1'b0, 1'b1, 21'h000080},
      '{8'hC0, 1'b0, 1'b0, 21'h000000},
      '{8'h80, 1'b0, 1'b1, 21'h000080},
      '{8'hE0, 1'b0, 1'b0, 21'h000000},
      '{8'hA0, 1'b0, 1'b0, 21'h000000},
      '{8'h80, 1'b0, 1'b1, 21'h000800},
      '{8'hED, 1'b0, 1'b0, 21'h000000},
      '{8'hA0, 1'b0, 1'b0, 21'h000000},
      '{8'h80, 1'b0, 1'b0, 21'h000000},
      '{8'hF4, 1'b0, 1'b0, 21'h000000},
      '{8'h8F, 1'b0, 1'b0, 21'h000000},
      '{8'hBF, 1'b0, 1'b0, 21'h000000},
      '{8'hBF, 1'b0, 1'b1, 21'h10FFFF},
      '{8'hF4, 1'b0, 1'b0, 21'h000000},
      '{8'h90, 1'b0, 1'b0, 21'h000000},
      '{8'h80, 1'b0, 1'b0, 21'h000000},
      '{8'h80, 1'b0, 1'b0, 21'h000000},
      '{8'hF0, 1'b0, 1'b0, 21'h000000},
      '{8'h90, 1'b0, 1'b0, 21'h000000},
      '{8'h41, 1'b0, 1'b0, 21'h000000},
      '{8'hE2, 1'b0, 1'b0, 21'h000000},
      '{8'h82, 1'b1, 1'b1, 21'h000082},
      '{8'hC3, 1'b1, 1'b0, 21'h000000},
      '{8'h7F, 1'b1, 1'b1, 21'h00007F}
   };

   utf8_to_codepoint_decoder_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_word  (req_word),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_word  (rsp_word)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_pop <= ($urandom_range(99) >= pop_stall_pct);
   end

   function automatic logic [2:0] utf8_len(input logic [7:0] b);
      logic [2:0] len;
      len = 3'd1;
      if ((b & 8'hE0) == 8'hC0) begin
         len = 3'd2;
      end else if ((b & 8'hF0) == 8'hE0) begin
         len = 3'd3;
      end else if ((b & 8'hF8) == 8'hF0) begin
         len = 3'd4;
      end
      return len;
   endfunction

   task automatic replay_held();
      for (int i = 0; i + 1 < held_count && i < 2; i++) begin
         byte_results.insert(byte_results.size(), {13'd0, held_conts[i]});
      end
   endtask

   task automatic decode_byte(input logic [7:0] b, input logic eot);
      logic        fresh;
      logic        ok;
      logic [2:0]  need;
      logic [20:0] cp;
      byte_results.delete();
      fresh = 1'b1;
      if (held_count != 2'd0) begin
         need = utf8_len(held_lead);
         if (b[7:6] == 2'b10) begin
            fresh = 1'b0;
            if ({1'b0, held_count} + 3'd1 >= need) begin
               case (need)
                  3'd2: begin
                     cp = {10'd0, held_lead[4:0], b[5:0]};
                     ok = cp >= 21'h80;
                  end
                  3'd3: begin
                     cp = {5'd0, held_lead[3:0], held_conts[0][5:0], b[5:0]};
                     ok = cp >= 21'h800 && (cp < 21'hD800 || cp > 21'hDFFF);
                  end
                  default: begin
                     cp = {held_lead[2:0], held_conts[0][5:0], held_conts[1][5:0], b[5:0]};
                     ok = cp >= 21'h10000 && cp <= 21'h10FFFF;
                  end
               endcase
               if (ok) begin
                  byte_results.insert(byte_results.size(), cp);
               end else begin
                  replay_held();
                  byte_results.insert(byte_results.size(), {13'd0, b});
               end
               held_count = 2'd0;
            end else if (eot) begin
               replay_held();
               byte_results.insert(byte_results.size(), {13'd0, b});
               held_count = 2'd0;
            end else begin
               held_conts[1'(held_count - 2'd1)] = b;
               held_count = held_count + 2'd1;
            end
         end else begin
            replay_held();
            held_count = 2'd0;
         end
      end
      if (fresh) begin
         if (utf8_len(b) == 3'd1) begin
            byte_results.insert(byte_results.size(), {13'd0, b});
         end else if (!eot) begin
            held_lead = b;
            held_count = 2'd1;
         end
      end
      if (eot) begin
         held_count = 2'd0;
      end
   endtask

   task automatic send_word(input u2c_pkg::req_word_type w, input logic typed,
                            input logic [20:0] typed_cp);
      u2c_pkg::rsp_word_type e;
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(negedge clock);
      end
      req_push <= 1'b1;
      req_word <= w;
      @(posedge clock);
      while (req_full) @(posedge clock);
      decode_byte(w.text_byte, w.end_of_text);
      if (typed) begin
         e.code_point = typed_cp;
         e.last_in_run = 1'b1;
         e.text_done = w.end_of_text;
         awaited_code_points.insert(awaited_code_points.size(), e);
      end else begin
         foreach (byte_results[k]) begin
            e.code_point = byte_results[k];
            e.last_in_run = (k == byte_results.size() - 1);
            e.text_done = w.end_of_text;
            awaited_code_points.insert(awaited_code_points.size(), e);
         end
      end
      bytes_sent++;
      if (w.end_of_text) texts_ended++;
      @(negedge clock);
   endtask

   task automatic report_fault(input string what, input u2c_pkg::rsp_word_type want,
                               input u2c_pkg::rsp_word_type got);
      fault_count++;
      if (fault_count <= MAX_REPORTS) begin
         $display("%0t %s: expected cp=%h last=%b done=%b, got cp=%h last=%b done=%b",
                  $realtime, what, want.code_point, want.last_in_run, want.text_done,
                  got.code_point, got.last_in_run, got.text_done);
      end
   endtask

   always @(posedge clock) begin
      u2c_pkg::rsp_word_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         words_checked++;
         if (awaited_code_points.size() == 0) begin
            report_fault("unexpected word", '0, rsp_word);
         end else begin
            want = awaited_code_points.pop_front();
            if (rsp_word.code_point !== want.code_point) begin
               report_fault("code_point mismatch", want, rsp_word);
            end else if (rsp_word.last_in_run !== want.last_in_run) begin
               report_fault("last_in_run mismatch", want, rsp_word);
            end else if (rsp_word.text_done !== want.text_done) begin
               report_fault("text_done mismatch", want, rsp_word);
            end
         end
      end
   end

   task automatic push_encoded(input logic [20:0] cp, input int len);
      case (len)
         1: text_bytes.insert(text_bytes.size(), {1'b0, cp[6:0]});
         2: begin
            text_bytes.insert(text_bytes.size(), {3'b110, cp[10:6]});
            text_bytes.insert(text_bytes.size(), {2'b10, cp[5:0]});
         end
         3: begin
            text_bytes.insert(text_bytes.size(), {4'b1110, cp[15:12]});
            text_bytes.insert(text_bytes.size(), {2'b10, cp[11:6]});
            text_bytes.insert(text_bytes.size(), {2'b10, cp[5:0]});
         end
         default: begin
            text_bytes.insert(text_bytes.size(), {5'b11110, cp[20:18]});
            text_bytes.insert(text_bytes.size(), {2'b10, cp[17:12]});
            text_bytes.insert(text_bytes.size(), {2'b10, cp[11:6]});
            text_bytes.insert(text_bytes.size(), {2'b10, cp[5:0]});
         end
      endcase
   endtask

   function automatic logic [20:0] legal_code_point(input int len);
      logic [20:0] cp;
      case (len)
         1: cp = 21'($urandom_range(127, 0));
         2: cp = 21'($urandom_range(2047, 128));
         3: begin
            cp = 21'($urandom_range(65535, 2048));
            if (cp >= 21'hD800 && cp <= 21'hDFFF) cp = cp + 21'h800;
         end
         default: cp = 21'($urandom_range(21'h10FFFF, 21'h10000));
      endcase
      return cp;
   endfunction

   task automatic make_sequence();
      int pick;
      int len;
      int cut;
      text_bytes.delete();
      pick = $urandom_range(99);
      if (pick < 55) begin
         len = $urandom_range(4, 1);
         push_encoded(legal_code_point(len), len);
      end else if (pick < 70) begin
         // random payload in a long form: overlong, surrogate and out-of-range values
         len = $urandom_range(4, 2);
         push_encoded(21'($urandom), len);
      end else if (pick < 80) begin
         len = $urandom_range(4, 2);
         push_encoded(legal_code_point(len), len);
         cut = $urandom_range(len - 1, 1);
         repeat (cut) void'(text_bytes.pop_back());
      end else if (pick < 90) begin
         len = $urandom_range(4, 2);
         push_encoded(legal_code_point(len), len);
         text_bytes[$urandom_range(len - 1)] = 8'($urandom);
      end else begin
         repeat ($urandom_range(3, 1)) text_bytes.insert(text_bytes.size(), 8'($urandom));
      end
   endtask

   initial begin
      u2c_pkg::req_word_type w;
      int random_sent;
      logic end_pick;
      random_sent = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (byte_cases[i]) begin
         w.text_byte = byte_cases[i].value;
         w.end_of_text = byte_cases[i].eot;
         send_word(w, byte_cases[i].typed, byte_cases[i].cp);
      end

      while (random_sent < RANDOM_ITEMS) begin
         case ((random_sent * 4) / RANDOM_ITEMS)
            0: begin send_idle_pct = 0;  pop_stall_pct = 0;  end
            1: begin send_idle_pct = 67; pop_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  pop_stall_pct = 67; end
            default: begin send_idle_pct = 24; pop_stall_pct = 24; end
         endcase
         make_sequence();
         end_pick = ($urandom_range(11) == 0);
         foreach (text_bytes[k]) begin
            w.text_byte = text_bytes[k];
            w.end_of_text = (k == text_bytes.size() - 1 && end_pick) ||
                            ($urandom_range(49) == 0);
            send_word(w, 1'b0, 21'd0);
            random_sent++;
         end
      end
      req_push <= 1'b0;

      while (awaited_code_points.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("Sent %0d bytes (%0d closing a text) over four pacing phases; checked %0d words.",
               bytes_sent, texts_ended, words_checked);
      $display("Faults found: %0d", fault_count);
      if (fault_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Timeout with %0d words still awaited", awaited_code_points.size());
      $display("TEST FAILED");
      $finish;
   end

endmodule
